>>> design/bba_pkg.sv
// ---------------------------------------------------------------------------
// Bitmap block allocator package
// Shared widths, codes, payload types and the controller/datapath interface.
// ---------------------------------------------------------------------------
package bba_pkg;

   localparam int DEF_MAX_BLOCKS = 4096;
   localparam int DEF_WORD_BITS  = 64;

   localparam int BLOCK_W  = 12;
   localparam int COUNT_W  = 13;
   localparam int STATUS_W = 2;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_TOTAL_BLOCKS   = 2'd0;
   localparam logic [COUNT_W-1:0]    TOTAL_BLOCKS_RESET = 13'd4096;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ALREADY_FREE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE = 2'd3;

   typedef struct packed {
      logic               operation;
      logic [BLOCK_W-1:0] block_number;
   } bba_req_type;

   typedef struct packed {
      logic [BLOCK_W-1:0]  granted_block;
      logic [STATUS_W-1:0] status;
   } bba_rsp_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic advance;
      logic commit;
   } bba_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic done;
   } bba_sts_type;

endpackage

>>> design/bba_dpath.sv
// ---------------------------------------------------------------------------
// Bitmap block allocator datapath
// Holds the bitmap memory, walks it one word per cycle and forms the result.
// ---------------------------------------------------------------------------
module bba_dpath import bba_pkg::*; #(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
   parameter int WORD_BITS  = DEF_WORD_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  bba_cmd_type        cmd,
   input  bba_req_type        req_data,
   input  logic [COUNT_W-1:0] eff_count,
   output bba_sts_type        sts,
   output bba_rsp_type        rsp_data
);

   localparam int WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int BPW   = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0] mem [WORDS];

   logic [WAW-1:0]       clr_addr_ff, clr_addr_in;
   logic [WAW-1:0]       word_ff;
   logic [COUNT_W-1:0]   base_ff;
   logic [COUNT_W-1:0]   cnt_rem_ff;
   logic [BLOCK_W-1:0]   blk_rem_ff;
   logic                 op_ff;
   logic [BLOCK_W-1:0]   blk_ff;
   logic                 oor_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   bba_rsp_type          rsp_ff;

   logic [WORD_BITS-1:0] valid_mask;
   logic [WORD_BITS-1:0] free_bits;
   logic                 found;
   logic [BPW-1:0]       pos;
   logic                 alloc_last;
   logic                 blk_hit;
   logic [BPW-1:0]       bit_sel;
   logic                 bit_set;
   logic                 done;
   logic                 wr_needed;
   logic [WORD_BITS-1:0] new_word;
   bba_rsp_type          result;
   logic                 rd_en;
   logic [WAW-1:0]       rd_addr;
   logic                 wr_en;
   logic [WAW-1:0]       wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [COUNT_W-1:0]   alloc_block;

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         valid_mask[b] = COUNT_W'(b) < cnt_rem_ff;
      end
      free_bits = ~rd_data_ff & valid_mask;
      found = 1'b0;
      pos   = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            found = 1'b1;
            pos   = BPW'(b);
         end
      end
   end

   assign alloc_last  = cnt_rem_ff <= COUNT_W'(WORD_BITS);
   assign blk_hit     = blk_rem_ff < BLOCK_W'(WORD_BITS);
   assign bit_sel     = blk_rem_ff[BPW-1:0];
   assign bit_set     = rd_data_ff[bit_sel];
   assign alloc_block = COUNT_W'(base_ff + COUNT_W'(pos));

   always_comb begin
      wr_needed = 1'b0;
      new_word  = rd_data_ff;
      result    = '0;
      if (op_ff == OP_FREE) begin
         done                 = oor_ff || blk_hit;
         result.granted_block = blk_ff;
         if (oor_ff) begin
            result.status = STATUS_OUT_OF_RANGE;
         end else if (bit_set) begin
            result.status = STATUS_OK;
            wr_needed     = 1'b1;
            new_word      = rd_data_ff & ~(WORD_BITS'(1) << bit_sel);
         end else begin
            result.status = STATUS_ALREADY_FREE;
         end
      end else begin
         done = found || alloc_last;
         if (found) begin
            result.granted_block = alloc_block[BLOCK_W-1:0];
            result.status        = STATUS_OK;
            wr_needed            = 1'b1;
            new_word             = rd_data_ff | (WORD_BITS'(1) << pos);
         end else begin
            result.status = STATUS_NO_FREE;
         end
      end
   end

   assign rd_en   = cmd.load || cmd.advance;
   assign rd_addr = cmd.load ? '0 : WAW'(word_ff + 1'b1);
   assign wr_en   = cmd.clear || (cmd.commit && wr_needed);
   assign wr_addr = cmd.clear ? clr_addr_ff : word_ff;
   assign wr_data = cmd.clear ? '0 : new_word;

   assign clr_addr_in = cmd.clear ? WAW'(clr_addr_ff + 1'b1) : clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_data.operation;
         blk_ff     <= req_data.block_number;
         oor_ff     <= (req_data.operation == OP_FREE) &&
                       (COUNT_W'(req_data.block_number) >= eff_count);
         cnt_rem_ff <= eff_count;
         blk_rem_ff <= req_data.block_number;
         base_ff    <= '0;
         word_ff    <= '0;
      end else if (cmd.advance) begin
         cnt_rem_ff <= COUNT_W'(cnt_rem_ff - COUNT_W'(WORD_BITS));
         blk_rem_ff <= BLOCK_W'(blk_rem_ff - BLOCK_W'(WORD_BITS));
         base_ff    <= COUNT_W'(base_ff + COUNT_W'(WORD_BITS));
         word_ff    <= WAW'(word_ff + 1'b1);
      end
      if (cmd.commit) begin
         rsp_ff <= result;
      end
   end

   assign sts.clear_last = clr_addr_ff == WAW'(WORDS - 1);
   assign sts.done       = done;
   assign rsp_data       = rsp_ff;

endmodule

>>> design/bba_ctrl.sv
// ---------------------------------------------------------------------------
// Bitmap block allocator controller
// Sequences the clearing pass, item intake, the word scan and the result.
// ---------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  bba_sts_type sts,
   output bba_cmd_type cmd
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!sts.done) begin
               cmd.advance = 1'b1;
            end else if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_SCAN))
      else $error("result appeared without a finished scan");

   a_commit_done: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.done)
      else $error("commit before the scan finished");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("commit would overwrite a waiting result");

   a_step_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.advance && cmd.commit) && !(cmd.load && cmd.clear))
      else $error("conflicting datapath commands");

endmodule

>>> design/bitmap_block_allocator.sv
// ---------------------------------------------------------------------------
// Bitmap block allocator
// Allocates the lowest free block below the configured count and frees blocks,
// keeping one used bit per block in a word-organized bitmap memory.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   bba_req_type: operation, block
//   rsp      out        rsp_valid/rsp_stall   bba_rsp_type: block, status
//   csr      in/out     APB write/read        total_blocks at address 0
//
// An item is taken while the block is idle and then scans one bitmap word per cycle.
// An allocate scans until it finds a free bit or reaches the last word below
// the count, a free scans up to the word of its block, and an out-of-range free
// ends at the first word. After reset a clearing pass zeroes every memory word
// while req_stall stays high.
// A stalled result holds the last scan cycle; no new item is taken meanwhile.
// ---------------------------------------------------------------------------
module bitmap_block_allocator import bba_pkg::*; #(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
   parameter int WORD_BITS  = DEF_WORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bba_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bba_rsp_type           rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [COUNT_W-1:0] total_blocks_ff, total_blocks_in;
   logic [COUNT_W-1:0] eff_count;
   logic               csr_write;
   bba_cmd_type        cmd;
   bba_sts_type        sts;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr == REG_TOTAL_BLOCKS);
   assign total_blocks_in = csr_write ? csr_pwdata[COUNT_W-1:0] : total_blocks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_blocks_ff <= TOTAL_BLOCKS_RESET;
      end else begin
         total_blocks_ff <= total_blocks_in;
      end
   end

   assign csr_prdata = (csr_paddr == REG_TOTAL_BLOCKS) ?
                       CSR_DATA_W'(total_blocks_ff) : '0;

   assign eff_count = (32'(total_blocks_ff) > 32'(MAX_BLOCKS)) ?
                      COUNT_W'(MAX_BLOCKS) : total_blocks_ff;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bba_dpath #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .WORD_BITS  (WORD_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .eff_count (eff_count),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule
